// File: rtl/ccl_pkg.sv
// shared types for the connected component labeling first pass
package ccl_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_W       = 12;
    localparam int FIELD_W     = 12;
    localparam int ROW_W       = 11;
    localparam int ROW_LIMIT   = 2048;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    typedef struct packed {
        logic fg;
        logic row_nz;
        logic last_col;
        logic last_row;
    } t_ctl;

endpackage

// File: rtl/connected_component_label_first_pass.sv
// top level of the connected component labeling first pass
//
// Pixels enter in raster order on i_valid / o_stall with i_blue, i_green, i_red.
// Each pixel gives one transaction on o_valid / i_stall: its provisional label,
// an end-of-frame marker, the label count on the last pixel of the frame and
// a sticky overflow flag. Frame width and height are written on the config
// channel (index 0 width, index 1 height); the user must write them only while
// the block is idle, which it does not enforce. o_cfg_ready is always high.
// The front part classifies pixels and tracks the raster position; a
// two-entry queue decouples it from the back part, whose sequencer reads the
// line buffer twice, reads the equivalence table four times and writes it up
// to four times, all through memories with one read port and one write port.
// The back part works on one pixel at a time and pops the next from the queue
// only after it has finished the last one and returned to idle.
// While i_stall is high the result register holds; the back part finishes
// the next pixel and waits, and the queue absorbs up to two more pixels.
// Reset restores 640 x 480, label counter 1 and an empty pipeline; memory
// contents need no clearing.
module connected_component_label_first_pass import ccl_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_LABELS = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_blue,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_red,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [FIELD_W-1:0]     o_pixel_label,
    output logic                   o_end_of_frame,
    output logic [FIELD_W-1:0]     o_label_count,
    output logic                   o_label_overflow,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(t_ctl) + CW;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    t_ctl          f_ctl;
    logic [CW-1:0] f_col;
    logic [DW-1:0] q_data;

    assign o_cfg_ready = 1'b1;

    ccl_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_blue      (i_blue),
        .i_green     (i_green),
        .i_red       (i_red),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_ctl       (f_ctl),
        .o_col       (f_col)
    );

    ccl_queue #(.DW(DW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_col}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    ccl_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_LABELS(MAX_LABELS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_ctl            (t_ctl'(q_data[DW-1:CW])),
        .i_col            (q_data[CW-1:0]),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_label    (o_pixel_label),
        .o_end_of_frame   (o_end_of_frame),
        .o_label_count    (o_label_count),
        .o_label_overflow (o_label_overflow)
    );

endmodule

// File: rtl/ccl_front.sv
// front part: pixel classification and raster position tracking
module ccl_front import ccl_pkg::*; #(
    parameter int MAX_WIDTH = 2048,
    parameter int CW = $clog2(MAX_WIDTH)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_blue,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_red,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_ctl                   o_ctl,
    output logic [CW-1:0]          o_col
);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [13:0]      w_eff;
    logic [CFG_W-1:0] h_eff;
    logic             last_col;
    logic             last_row;

    always_comb begin
        if (r_width == '0) begin
            w_eff = 14'd1;
        end else if (14'(r_width) > 14'(MAX_WIDTH)) begin
            w_eff = 14'(MAX_WIDTH);
        end else begin
            w_eff = 14'(r_width);
        end
        if (r_height == '0) begin
            h_eff = 12'd1;
        end else if (r_height > 12'(ROW_LIMIT)) begin
            h_eff = 12'(ROW_LIMIT);
        end else begin
            h_eff = r_height;
        end
    end

    assign last_col = (14'(r_col) + 14'd1) >= w_eff;
    assign last_row = (12'(r_row) + 12'd1) >= h_eff;

    assign o_stall        = i_q_full;
    assign o_push         = i_valid && !i_q_full;
    assign o_col          = r_col;
    assign o_ctl.fg       = (i_blue | i_green | i_red) != 8'd0;
    assign o_ctl.row_nz   = r_row != '0;
    assign o_ctl.last_col = last_col;
    assign o_ctl.last_row = last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index == REG_FRAME_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == REG_FRAME_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (o_push) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/ccl_queue.sv
// two-entry queue between front and back parts
module ccl_queue #(
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output logic [DW-1:0] o_data
);

    logic [DW-1:0] r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: rtl/ccl_back.sv
// back part: neighbor lookup, equivalence table update and result register
module ccl_back import ccl_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_LABELS = 4096,
    parameter int CW = $clog2(MAX_WIDTH),
    parameter int LW = $clog2(MAX_LABELS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_ctl               i_ctl,
    input  logic [CW-1:0]      i_col,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_pixel_label,
    output logic               o_end_of_frame,
    output logic [FIELD_W-1:0] o_label_count,
    output logic               o_label_overflow
);

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_UR, S_RD, S_DEC, S_WR, S_FIN
    } t_state;

    t_state        r_state;
    t_ctl          r_ctl;
    logic [CW-1:0] r_col;
    logic [LW-1:0] r_up;
    logic [LW-1:0] r_nb [4];
    logic [LW-1:0] r_nv [4];
    logic [2:0]    r_k;
    logic          r_rd_zero;
    logic [LW-1:0] r_label;
    logic [LW-1:0] r_left;
    logic [LW-1:0] r_diag;
    logic [LW:0]   r_next;
    logic          r_ovf;
    logic          r_out_valid;

    logic [LW-1:0] lb_mem [MAX_WIDTH];
    logic [LW-1:0] r_lb_q;
    logic [CW-1:0] lb_ra;
    logic          lb_we;

    logic [LW-1:0] eq_mem [MAX_LABELS];
    logic [LW-1:0] r_eq_q;
    logic [LW-1:0] eq_ra;
    logic          eq_we;
    logic [LW-1:0] eq_wa;
    logic [LW-1:0] eq_wd;

    logic [LW:0]   lowest;
    logic          out_free;
    logic          fresh_ok;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;
    assign fresh_ok = r_next < (LW+1)'(MAX_LABELS);

    always_comb begin
        lowest = r_next;
        for (int i = 0; i < 4; i++) begin
            if (r_nv[i] != '0 && {1'b0, r_nv[i]} < lowest) begin
                lowest = {1'b0, r_nv[i]};
            end
        end
    end

    always_comb begin
        lb_ra = (r_state == S_IDLE) ? i_col : r_col + 1'b1;
        lb_we = (r_state == S_FIN) && out_free;
        eq_ra = r_nb[r_k[1:0]];
        eq_we = 1'b0;
        eq_wa = r_nb[r_k[1:0]];
        eq_wd = r_label;
        case (r_state)
            S_DEC: begin
                eq_wa = r_next[LW-1:0];
                eq_wd = r_next[LW-1:0];
                eq_we = (lowest == r_next) && fresh_ok;
            end
            S_WR: begin
                eq_we = r_nv[r_k[1:0]] != '0;
            end
            default: begin
                eq_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            lb_mem[r_col] <= r_label;
        end
        r_lb_q <= lb_mem[lb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (eq_we) begin
            eq_mem[eq_wa] <= eq_wd;
        end
        r_eq_q <= eq_mem[eq_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_left      <= '0;
            r_diag      <= '0;
            r_next      <= (LW+1)'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_FIN) && out_free) || (r_out_valid && i_stall);
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_ctl   <= i_ctl;
                        r_col   <= i_col;
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    r_up    <= r_lb_q;
                    r_state <= S_UR;
                end
                S_UR: begin
                    r_nb[0] <= r_ctl.row_nz ? r_up : '0;
                    r_nb[1] <= (r_ctl.row_nz && r_col != '0) ? r_diag : '0;
                    r_nb[2] <= (r_ctl.row_nz && !r_ctl.last_col) ? r_lb_q : '0;
                    r_nb[3] <= (r_col != '0) ? r_left : '0;
                    r_k     <= '0;
                    r_label <= '0;
                    r_state <= r_ctl.fg ? S_RD : S_FIN;
                end
                S_RD: begin
                    r_rd_zero <= eq_ra == '0;
                    if (r_k != 3'd0) begin
                        r_nv[2'(r_k - 3'd1)] <= r_rd_zero ? '0 : r_eq_q;
                    end
                    if (r_k == 3'd4) begin
                        r_state <= S_DEC;
                    end
                    r_k <= r_k + 3'd1;
                end
                S_DEC: begin
                    r_k <= '0;
                    if (lowest == r_next) begin
                        if (fresh_ok) begin
                            r_label <= r_next[LW-1:0];
                            r_next  <= r_next + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end else begin
                        r_label <= lowest[LW-1:0];
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd3) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_pixel_label    <= FIELD_W'(r_label);
                        o_end_of_frame   <= r_ctl.last_col && r_ctl.last_row;
                        o_label_count    <= (r_ctl.last_col && r_ctl.last_row) ?
                                            FIELD_W'(r_next - 1'b1) : '0;
                        o_label_overflow <= r_ovf;
                        r_diag           <= r_ctl.last_col ? '0 : r_up;
                        r_left           <= r_ctl.last_col ? '0 : r_label;
                        if (r_ctl.last_col && r_ctl.last_row) begin
                            r_next <= (LW+1)'(1);
                            r_ovf  <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/ccl_checker.sv
// port-level checker for the connected component labeling first pass
module ccl_checker import ccl_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [FIELD_W-1:0] o_pixel_label,
    input logic               o_end_of_frame,
    input logic [FIELD_W-1:0] o_label_count,
    input logic               o_label_overflow
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_label))
        else $error("stalled result changed");

    a_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_end_of_frame |-> o_label_count == '0)
        else $error("label count outside end of frame");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_label_overflow && !o_end_of_frame
        |=> !o_valid || o_label_overflow)
        else $error("overflow flag dropped within frame");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind connected_component_label_first_pass ccl_checker u_ccl_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_pixel_label    (o_pixel_label),
    .o_end_of_frame   (o_end_of_frame),
    .o_label_count    (o_label_count),
    .o_label_overflow (o_label_overflow)
);

// File: verif/testbench.sv
// self-checking testbench for the connected component labeling first pass
`timescale 1ns / 1ps

module testbench;
    import ccl_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [FIELD_W-1:0] label;
        logic               eof;
        logic [FIELD_W-1:0] count;
        logic               overflow;
    } t_label_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_blue = '0;
    logic [7:0]         i_green = '0;
    logic [7:0]         i_red = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [FIELD_W-1:0] o_pixel_label;
    logic               o_end_of_frame;
    logic [FIELD_W-1:0] o_label_count;
    logic               o_label_overflow;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;

    connected_component_label_first_pass uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pixel        pending_pixels[$];
    t_label_result expected_labels[$];
    int            error_count = 0;
    int            results_seen = 0;

    // predictor state
    logic [CFG_W-1:0]   cfg_width = 12'd640;
    logic [CFG_W-1:0]   cfg_height = 12'd480;
    logic [FIELD_W-1:0] line_labels[2048];
    logic [FIELD_W-1:0] equiv[4096];
    logic [FIELD_W-1:0] left_lab = '0;
    logic [FIELD_W-1:0] diag_lab = '0;
    int                 next_lab = 1;
    int                 col_pos = 0;
    int                 row_pos = 0;
    logic               ovf_flag = 1'b0;

    initial begin
        for (int i = 0; i < 2048; i++) line_labels[i] = '0;
        for (int i = 0; i < 4096; i++) equiv[i] = '0;
    end

    function automatic int eff_width(input logic [CFG_W-1:0] v);
        int w;
        w = (v == 0) ? 1 : int'(v);
        return (w > 2048) ? 2048 : w;
    endfunction

    function automatic int eff_height(input logic [CFG_W-1:0] v);
        int h;
        h = (v == 0) ? 1 : int'(v);
        return (h > ROW_LIMIT) ? ROW_LIMIT : h;
    endfunction

    task automatic label_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        int w, h, col, row, lowest;
        logic [FIELD_W-1:0] up, lab;
        logic [FIELD_W-1:0] nb[4];
        logic [FIELD_W-1:0] nv[4];
        bit fg, lc, lr;
        t_label_result res;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        col = (col_pos < 2048) ? col_pos : 2047;
        row = row_pos;
        lc = (col + 1 >= w);
        lr = (row + 1 >= h);
        fg = (b | g | r) != 0;
        up = line_labels[col];
        nb[0] = (row > 0) ? up : '0;
        nb[1] = (row > 0 && col > 0) ? diag_lab : '0;
        nb[2] = (row > 0 && !lc && col + 1 < 2048) ? line_labels[col+1] : '0;
        nb[3] = (col > 0) ? left_lab : '0;
        lab = '0;
        if (fg) begin
            lowest = next_lab;
            for (int i = 0; i < 4; i++) begin
                nv[i] = equiv[nb[i]];
                if (nv[i] != 0 && int'(nv[i]) < lowest) lowest = int'(nv[i]);
            end
            if (lowest == next_lab) begin
                if (next_lab < 4096) begin
                    lab = next_lab[FIELD_W-1:0];
                    equiv[lab] = lab;
                    next_lab++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end else begin
                lab = lowest[FIELD_W-1:0];
                for (int i = 0; i < 4; i++)
                    if (nv[i] != 0 && nb[i] != 0) equiv[nb[i]] = lab;
            end
        end
        diag_lab = up;
        line_labels[col] = lab;
        left_lab = lab;
        res.label = lab;
        res.eof = lc && lr;
        res.count = (lc && lr) ? FIELD_W'(next_lab - 1) : '0;
        res.overflow = ovf_flag;
        expected_labels = {expected_labels, res};
        if (lc) begin
            col_pos = 0;
            left_lab = '0;
            diag_lab = '0;
            if (lr) begin
                next_lab = 1;
                ovf_flag = 1'b0;
                row_pos = 0;
            end else begin
                row_pos = row + 1;
            end
        end else begin
            col_pos = col + 1;
        end
    endtask

    // driver: bursts with random gaps
    int burst_left = 8;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_pixel p;
        if (i_valid && !o_stall) label_pixel(i_blue, i_green, i_red);
        if (!(i_valid && o_stall)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                p = pending_pixels.pop_front();
                i_blue <= p.blue;
                i_green <= p.green;
                i_red <= p.red;
                i_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int  stall_mode = 0;
    int  mode_left = 300;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= 300 && pending_pixels.size() > 50) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            mode_left--;
            if (mode_left <= 0) begin
                mode_left = $urandom_range(50, 600);
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_label_result e;
        if (o_valid && !i_stall) begin
            results_seen++;
            if (expected_labels.size() == 0) begin
                $display("%0t: unexpected transaction label %0d", $time, o_pixel_label);
                error_count++;
            end else begin
                e = expected_labels.pop_front();
                if (o_pixel_label !== e.label) begin
                    $display("%0t: pixel_label expected %0d actual %0d",
                             $time, e.label, o_pixel_label);
                    error_count++;
                end
                if (o_end_of_frame !== e.eof) begin
                    $display("%0t: end_of_frame expected %0d actual %0d",
                             $time, e.eof, o_end_of_frame);
                    error_count++;
                end
                if (o_label_count !== e.count) begin
                    $display("%0t: label_count expected %0d actual %0d",
                             $time, e.count, o_label_count);
                    error_count++;
                end
                if (o_label_overflow !== e.overflow) begin
                    $display("%0t: label_overflow expected %0d actual %0d",
                             $time, e.overflow, o_label_overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_pixels.size() > 0 || i_valid || expected_labels.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) cfg_width = val;
        else if (idx == REG_FRAME_HEIGHT) cfg_height = val;
    endtask

    function automatic t_pixel make_pixel(input bit fg);
        t_pixel p;
        p = '0;
        if (fg) begin
            case ($urandom_range(0, 4))
                0: p.blue = 8'($urandom_range(1, 255));
                1: p.green = 8'($urandom_range(1, 255));
                2: p.red = 8'($urandom_range(1, 255));
                3: p = '1;
                default: p = 24'($urandom);
            endcase
            if (p == '0) p.red = 8'h80;
        end
        return p;
    endfunction

    // style: 0 random density, 1 isolated grid, 2 all background, 3 all foreground
    task automatic run_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int style);
        int ew, eh, density;
        bit fg;
        t_pixel px;
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        ew = eff_width(w);
        eh = eff_height(h);
        density = $urandom_range(5, 95);
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++) begin
                case (style)
                    1: fg = (x % 2 == 0) && (y % 2 == 0);
                    2: fg = 1'b0;
                    3: fg = 1'b1;
                    default: fg = ($urandom_range(0, 99) < density);
                endcase
                px = make_pixel(fg);
                pending_pixels = {pending_pixels, px};
            end
    endtask

    initial begin
        int random_items;
        int w, h;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_frame(12'd0, 12'd0, 3);
        run_frame(12'd0, 12'd0, 2);
        run_frame(12'd0, 12'd3, 3);
        run_frame(12'd5, 12'd3, 3);
        run_frame(12'd6, 12'd4, 2);
        run_frame(12'd40, 12'd8, 1);
        run_frame(12'd33, 12'd5, 0);
        random_items = 529;
        while (random_items < 1750) begin
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(65, 200);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 64);
                h = $urandom_range(1, 16);
            end
            if (random_items + w * h > 1800) h = (1800 - random_items) / w;
            if (h < 1) h = 1;
            run_frame(CFG_W'(w), CFG_W'(h), ($urandom_range(0, 7) == 0) ? 3 : 0);
            random_items += w * h;
        end
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ccl_pkg.sv
rtl/ccl_front.sv
rtl/ccl_queue.sv
rtl/ccl_back.sv
rtl/connected_component_label_first_pass.sv
rtl/ccl_checker.sv
verif/testbench.sv
